// ===== rtl/tga_rle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  // configuration bus
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register indexes, word address paddr[3:2]
  localparam logic [1:0] REG_RUN_LENGTH_MODE  = 2'd0;
  localparam logic [1:0] REG_FOUR_BYTE_PIXELS = 2'd1;
  localparam logic [1:0] REG_TOTAL_PIXELS     = 2'd2;

  // packet header byte layout
  localparam int unsigned HDR_RUN_BIT = 7;

  // byte position inside a pixel, file order b, g, r, a
  localparam logic [1:0] POS_BLUE  = 2'd0;
  localparam logic [1:0] POS_GREEN = 2'd1;
  localparam logic [1:0] POS_RED   = 2'd2;
  localparam logic [1:0] POS_ALPHA = 2'd3;

  // configuration registers
  typedef struct packed {
    logic        run_length_mode;
    logic        four_byte_pixels;
    logic [31:0] total_pixels;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    logic       overflow_error;
  } res_t;

endpackage : tga_rle_pkg
`default_nettype wire

// ===== rtl/tga_rle_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_cfg
// APB-style register file: image type, pixel depth and pixel count.
// ----------------------------------------------------------------------------
module tga_rle_cfg
  import tga_rle_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RUN_LENGTH_MODE:  cfg_r.run_length_mode  <= pwdata[0];
        REG_FOUR_BYTE_PIXELS: cfg_r.four_byte_pixels <= pwdata[0];
        REG_TOTAL_PIXELS:     cfg_r.total_pixels     <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_RUN_LENGTH_MODE:  prdata[0] = cfg_r.run_length_mode;
      REG_FOUR_BYTE_PIXELS: prdata[0] = cfg_r.four_byte_pixels;
      REG_TOTAL_PIXELS:     prdata    = cfg_r.total_pixels;
      default:              prdata    = '0;
    endcase
  end

endmodule : tga_rle_cfg
`default_nettype wire

// ===== rtl/tga_rle_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_core
// Input register, packet parser and pixel assembler; one byte per cycle while results are accepted.
// ----------------------------------------------------------------------------
module tga_rle_core
  import tga_rle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_frame_start,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_t            res
);

  // input register
  logic       stage_v_r;
  logic [7:0] stage_byte_r;
  logic       stage_fs_r;

  // parser state
  logic        expect_hdr_r,  expect_hdr_nxt;
  logic        is_run_r,      is_run_nxt;
  logic [1:0]  pos_r,         pos_nxt;
  logic [7:0]  raw_left_r,    raw_left_nxt;
  logic [7:0]  run_len_r,     run_len_nxt;
  logic [23:0] pix_buf_r,     pix_buf_nxt;
  logic [31:0] done_r,        done_nxt;

  // state after an optional frame restart
  logic        expect_hdr_e;
  logic        is_run_e;
  logic [1:0]  pos_e;
  logic [7:0]  raw_left_e;
  logic [7:0]  run_len_e;
  logic [23:0] pix_buf_e;
  logic [31:0] done_e;

  logic [32:0] diff;
  logic [31:0] left;
  logic        finished;
  logic        small_left;
  logic [7:0]  rep;
  logic [7:0]  raw_dec;
  logic        clip;
  logic [7:0]  alpha;
  logic        emit;
  logic        advance;
  logic        in_xfer;
  res_t        res_c;

  assign advance  = stage_v_r && (!emit || res_ready);
  assign in_ready = !stage_v_r || advance;
  assign in_xfer  = in_valid && in_ready;

  assign res_valid = stage_v_r && emit;
  assign res       = res_c;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_xfer) begin
      stage_v_r <= 1'b1;
    end else if (advance) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_byte_r <= in_data_byte;
      stage_fs_r   <= in_frame_start;
    end
  end

  // frame start clears the parser before the byte is used
  always_comb begin
    if (stage_fs_r) begin
      expect_hdr_e = 1'b1;
      is_run_e     = 1'b0;
      pos_e        = POS_BLUE;
      raw_left_e   = '0;
      run_len_e    = '0;
      pix_buf_e    = '0;
      done_e       = '0;
    end else begin
      expect_hdr_e = expect_hdr_r;
      is_run_e     = is_run_r;
      pos_e        = pos_r;
      raw_left_e   = raw_left_r;
      run_len_e    = run_len_r;
      pix_buf_e    = pix_buf_r;
      done_e       = done_r;
    end
  end

  // pixels left in the image; borrow means the count was lowered below done
  assign diff       = {1'b0, cfg.total_pixels} - {1'b0, done_e};
  assign left       = diff[31:0];
  assign finished   = diff[32] || (left == '0);
  assign small_left = (left[31:8] == '0);

  // one byte of parsing
  always_comb begin
    expect_hdr_nxt = expect_hdr_e;
    is_run_nxt     = is_run_e;
    pos_nxt        = pos_e;
    raw_left_nxt   = raw_left_e;
    run_len_nxt    = run_len_e;
    pix_buf_nxt    = pix_buf_e;
    done_nxt       = done_e;
    emit           = 1'b0;
    res_c          = '0;
    rep            = 8'd1;
    raw_dec        = '0;
    clip           = 1'b0;
    alpha          = '0;

    if (finished) begin
      // past the end: byte dropped and flagged
      emit                 = 1'b1;
      res_c.overflow_error = 1'b1;
    end else if (cfg.run_length_mode && expect_hdr_e) begin
      // packet header
      is_run_nxt     = stage_byte_r[HDR_RUN_BIT];
      pos_nxt        = POS_BLUE;
      expect_hdr_nxt = 1'b0;
      if (stage_byte_r[HDR_RUN_BIT]) begin
        run_len_nxt  = {1'b0, stage_byte_r[6:0]} + 8'd1;
        raw_left_nxt = '0;
      end else begin
        raw_left_nxt = {1'b0, stage_byte_r[6:0]} + 8'd1;
        run_len_nxt  = '0;
      end
    end else begin
      // pixel byte into its lane
      case (pos_e)
        POS_BLUE:  pix_buf_nxt[7:0]   = stage_byte_r;
        POS_GREEN: pix_buf_nxt[15:8]  = stage_byte_r;
        POS_RED:   pix_buf_nxt[23:16] = stage_byte_r;
        default:   alpha = cfg.four_byte_pixels ? stage_byte_r : 8'd0;
      endcase

      if (pos_e == POS_BLUE || pos_e == POS_GREEN ||
          (cfg.four_byte_pixels && pos_e == POS_RED)) begin
        pos_nxt = pos_e + 2'd1;
      end else begin
        // pixel complete
        pos_nxt = POS_BLUE;
        if (cfg.run_length_mode) begin
          if (is_run_e) begin
            rep            = (run_len_e != '0) ? run_len_e : 8'd1;
            expect_hdr_nxt = 1'b1;
          end else begin
            raw_dec      = (raw_left_e != '0) ? raw_left_e - 8'd1 : 8'd0;
            raw_left_nxt = raw_dec;
            if (raw_dec == '0) begin
              expect_hdr_nxt = 1'b1;
            end
          end
        end

        // clip to the pixels left
        clip = small_left && (left[7:0] < rep);
        if (clip) begin
          done_nxt = cfg.total_pixels;
        end else begin
          done_nxt = done_e + {24'd0, rep};
        end

        emit                 = 1'b1;
        res_c.red            = pix_buf_nxt[23:16];
        res_c.green          = pix_buf_nxt[15:8];
        res_c.blue           = pix_buf_nxt[7:0];
        res_c.alpha          = alpha;
        res_c.repeat_count   = clip ? left[7:0] : rep;
        res_c.last_pixel     = clip || (small_left && left[7:0] == rep);
        res_c.overflow_error = clip;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      is_run_r     <= 1'b0;
      pos_r        <= POS_BLUE;
      raw_left_r   <= '0;
      run_len_r    <= '0;
      pix_buf_r    <= '0;
      done_r       <= '0;
    end else if (advance) begin
      expect_hdr_r <= expect_hdr_nxt;
      is_run_r     <= is_run_nxt;
      pos_r        <= pos_nxt;
      raw_left_r   <= raw_left_nxt;
      run_len_r    <= run_len_nxt;
      pix_buf_r    <= pix_buf_nxt;
      done_r       <= done_nxt;
    end
  end

endmodule : tga_rle_core
`default_nettype wire

// ===== rtl/tga_rle_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_out_buf
// Result register with a skid entry; ready toward the core is registered.
// ----------------------------------------------------------------------------
module tga_rle_out_buf
  import tga_rle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  output logic      res_ready,
  input  wire res_t res,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic main_v_r;
  logic skid_v_r;
  res_t main_r;
  res_t skid_r;
  logic push;

  assign res_ready = !skid_v_r;
  assign push      = res_valid && res_ready;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (main_v_r && !out_ready) begin
      if (push) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      main_v_r <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= push;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (main_v_r && !out_ready) begin
      if (push) begin
        skid_r <= res;
      end
    end else if (skid_v_r) begin
      main_r <= skid_r;
    end else if (push) begin
      main_r <= res;
    end
  end

endmodule : tga_rle_out_buf
`default_nettype wire

// ===== rtl/tga_rle_pixel_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA truecolor pixel-data decoder, raw or run-length, 24 or 32 bit pixels.
// Path: the byte that completes a pixel is held in the input register, and its
//   result then passes to the result register.
// Throughput: one byte per cycle while the output accepts results; header bytes
//   and partial-pixel bytes produce no result, every completed pixel or dropped byte produces one.
// Reset: synchronous rst_n clears the valid flags and configuration, and resets the parser state.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
  import tga_rle_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // byte input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_frame_start,
  // pixel output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [7:0]         out_red,
  output logic      [7:0]         out_green,
  output logic      [7:0]         out_blue,
  output logic      [7:0]         out_alpha,
  output logic      [7:0]         out_repeat_count,
  output logic                    out_last_pixel,
  output logic                    out_overflow_error
);

  cfg_t cfg;
  res_t core_res;
  logic core_res_valid;
  logic core_res_ready;
  res_t out_res;

  // register file
  tga_rle_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // parser
  tga_rle_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .res_valid      (core_res_valid),
    .res_ready      (core_res_ready),
    .res            (core_res)
  );

  // result register
  tga_rle_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_red            = out_res.red;
  assign out_green          = out_res.green;
  assign out_blue           = out_res.blue;
  assign out_alpha          = out_res.alpha;
  assign out_repeat_count   = out_res.repeat_count;
  assign out_last_pixel     = out_res.last_pixel;
  assign out_overflow_error = out_res.overflow_error;

  // a pixel that is not flagged always covers at least one pixel
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow_error |-> out_repeat_count != 8'd0)
    else $error("unflagged result with zero repeat count");

  // a dropped byte carries no pixel
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_repeat_count == 8'd0 |->
      out_overflow_error && !out_last_pixel && out_red == 8'd0 &&
      out_green == 8'd0 && out_blue == 8'd0 && out_alpha == 8'd0)
    else $error("zero-count result is not a clean drop");

  // a clipped result always ends the image
  a_clip_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_error && out_repeat_count != 8'd0 |->
      out_last_pixel)
    else $error("clipped result without last pixel");

  // the skid entry fills only while the head result is stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !core_res_ready |-> $past(out_valid && !out_ready))
    else $error("skid entry filled without a stall");

endmodule : tga_rle_pixel_decoder
`default_nettype wire
